// File: hdl/i2crts_pkg.sv
// shared types and constants for the i2c register transfer sequencer
package i2crts_pkg;

  localparam int COUNT_WIDTH = 8;
  localparam int MAX_RESULTS = 4;
  localparam logic [7:0] READ_FLAG = 8'h01;

  // host and bus request codes
  typedef enum logic [2:0] {
    CMD_PROBE      = 3'd0,
    CMD_BEGIN_WR   = 3'd1,
    CMD_BEGIN_RD   = 3'd2,
    CMD_ACK_REPORT = 3'd3,
    CMD_WRITE_BYTE = 3'd4,
    CMD_RX_BYTE    = 3'd5,
    CMD_UNUSED6    = 3'd6,
    CMD_UNUSED7    = 3'd7
  } cmd_t;

  // result action codes
  typedef enum logic [2:0] {
    ACT_START  = 3'd0,
    ACT_STOP   = 3'd1,
    ACT_SEND   = 3'd2,
    ACT_RECV   = 3'd3,
    ACT_ACKBIT = 3'd4,
    ACT_READ   = 3'd5,
    ACT_NEED   = 3'd6,
    ACT_DONE   = 3'd7
  } act_t;

  // transaction phase
  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_PROBE_ADDR = 4'd1,
    PH_W_ADDR     = 4'd2,
    PH_W_REG      = 4'd3,
    PH_W_WAIT     = 4'd4,
    PH_W_DATA     = 4'd5,
    PH_R_ADDR     = 4'd6,
    PH_R_REG      = 4'd7,
    PH_R_ADDR2    = 4'd8,
    PH_R_DATA     = 4'd9
  } phase_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] device_address;
    logic [7:0] register_index;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
    logic       nacked;
  } in_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_value;
    logic       ack_level;
    logic       success;
    logic       last;
  } out_item_t;

  // results caused by one request, entry 0 goes out first
  typedef struct packed {
    out_item_t [MAX_RESULTS-1:0] item;
    logic [2:0]                  count;
  } bundle_t;

  function automatic out_item_t mk_res(act_t act, logic [7:0] value, logic ack,
                                       logic ok);
    out_item_t r;
    r.action     = act;
    r.byte_value = value;
    r.ack_level  = ack;
    r.success    = ok;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

// File: hdl/i2c_register_transfer_sequencer_top.sv
// top level of the i2c register transfer sequencer
// a request is held in the input request register until the result register is free;
//   its results are then loaded there, and the first is offered from the result register
// a request with n results (1 to 4) holds the result register until the last one is taken;
//   requests with no results load nothing but still wait for the result register to be free
// reset: synchronous active-low rst_n returns the phase to idle and empties both registers
module i2c_register_transfer_sequencer_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2crts_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2crts_pkg::out_item_t out_data
);

  logic                 hold_vld_r;
  i2crts_pkg::in_item_t hold_r;
  logic                 take;
  logic                 load_ok;
  logic                 load;
  i2crts_pkg::bundle_t  bundle;

  assign in_ready = !hold_vld_r || take;
  assign load     = take && (bundle.count != 3'd0);

  // input request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (in_ready) begin
      hold_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_r <= in_data;
    end
  end

  i2crts_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (hold_vld_r),
    .item     (hold_r),
    .load_ok  (load_ok),
    .take     (take),
    .bundle   (bundle)
  );

  i2crts_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .bundle    (bundle),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hdl/i2crts_core.sv
// transaction state and per-request result decode
module i2crts_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_vld,
  input  i2crts_pkg::in_item_t item,
  input  logic                 load_ok,
  output logic                 take,
  output i2crts_pkg::bundle_t  bundle
);

  i2crts_pkg::phase_t              phase_r, phase_nxt;
  logic [7:0]                      addr_r, addr_nxt;
  logic [7:0]                      reg_r, reg_nxt;
  logic [i2crts_pkg::COUNT_WIDTH-1:0] left_r, left_nxt;

  i2crts_pkg::cmd_t                   cmd;
  logic [i2crts_pkg::COUNT_WIDTH-1:0] cnt;
  logic [i2crts_pkg::COUNT_WIDTH-1:0] left_wr;
  logic                               is_begin;

  assign take = item_vld && load_ok;

  // shared decode
  always_comb begin
    cmd      = i2crts_pkg::cmd_t'(item.command);
    cnt      = i2crts_pkg::COUNT_WIDTH'(item.byte_count);
    is_begin = (cmd == i2crts_pkg::CMD_PROBE) || (cmd == i2crts_pkg::CMD_BEGIN_WR) ||
               (cmd == i2crts_pkg::CMD_BEGIN_RD);
    // write byte count after an acknowledged register or data byte
    if (phase_r == i2crts_pkg::PH_W_DATA && left_r != '0) begin
      left_wr = left_r - i2crts_pkg::COUNT_WIDTH'(1);
    end else begin
      left_wr = left_r;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    addr_nxt  = addr_r;
    reg_nxt   = reg_r;
    left_nxt  = left_r;
    if (is_begin) begin
      if (phase_r == i2crts_pkg::PH_IDLE) begin
        addr_nxt = item.device_address;
        reg_nxt  = item.register_index;
        case (cmd)
          i2crts_pkg::CMD_PROBE: begin
            left_nxt  = '0;
            phase_nxt = i2crts_pkg::PH_PROBE_ADDR;
          end
          i2crts_pkg::CMD_BEGIN_WR: begin
            left_nxt  = cnt;
            phase_nxt = i2crts_pkg::PH_W_ADDR;
          end
          default: begin
            left_nxt  = (cnt == '0) ? i2crts_pkg::COUNT_WIDTH'(1) : cnt;
            phase_nxt = i2crts_pkg::PH_R_ADDR;
          end
        endcase
      end
    end else if (cmd == i2crts_pkg::CMD_ACK_REPORT) begin
      case (phase_r)
        i2crts_pkg::PH_PROBE_ADDR: begin
          phase_nxt = i2crts_pkg::PH_IDLE;
        end
        i2crts_pkg::PH_W_ADDR: begin
          phase_nxt = item.nacked ? i2crts_pkg::PH_IDLE : i2crts_pkg::PH_W_REG;
        end
        i2crts_pkg::PH_R_ADDR: begin
          phase_nxt = item.nacked ? i2crts_pkg::PH_IDLE : i2crts_pkg::PH_R_REG;
        end
        i2crts_pkg::PH_W_REG, i2crts_pkg::PH_W_DATA: begin
          if (item.nacked) begin
            phase_nxt = i2crts_pkg::PH_IDLE;
          end else begin
            left_nxt  = left_wr;
            phase_nxt = (left_wr == '0) ? i2crts_pkg::PH_IDLE : i2crts_pkg::PH_W_WAIT;
          end
        end
        i2crts_pkg::PH_R_REG: begin
          phase_nxt = item.nacked ? i2crts_pkg::PH_IDLE : i2crts_pkg::PH_R_ADDR2;
        end
        i2crts_pkg::PH_R_ADDR2: begin
          phase_nxt = item.nacked ? i2crts_pkg::PH_IDLE : i2crts_pkg::PH_R_DATA;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end else if (cmd == i2crts_pkg::CMD_WRITE_BYTE) begin
      if (phase_r == i2crts_pkg::PH_W_WAIT) begin
        phase_nxt = i2crts_pkg::PH_W_DATA;
      end
    end else if (cmd == i2crts_pkg::CMD_RX_BYTE) begin
      if (phase_r == i2crts_pkg::PH_R_DATA) begin
        if (left_r <= i2crts_pkg::COUNT_WIDTH'(1)) begin
          left_nxt  = '0;
          phase_nxt = i2crts_pkg::PH_IDLE;
        end else begin
          left_nxt  = left_r - i2crts_pkg::COUNT_WIDTH'(1);
        end
      end
    end
  end

  // results for this request
  always_comb begin
    bundle = '0;
    if (is_begin) begin
      if (phase_r == i2crts_pkg::PH_IDLE) begin
        bundle.item[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_START, 8'h00, 1'b0, 1'b0);
        bundle.item[1] = i2crts_pkg::mk_res(i2crts_pkg::ACT_SEND, item.device_address,
                                            1'b0, 1'b0);
        bundle.count   = 3'd2;
      end
    end else if (cmd == i2crts_pkg::CMD_ACK_REPORT) begin
      case (phase_r)
        i2crts_pkg::PH_PROBE_ADDR: begin
          bundle.item[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_STOP, 8'h00, 1'b0, 1'b0);
          bundle.item[1] = i2crts_pkg::mk_res(i2crts_pkg::ACT_DONE, 8'h00, 1'b0,
                                              !item.nacked);
          bundle.count   = 3'd2;
        end
        i2crts_pkg::PH_W_ADDR, i2crts_pkg::PH_R_ADDR, i2crts_pkg::PH_W_REG,
        i2crts_pkg::PH_W_DATA, i2crts_pkg::PH_R_REG, i2crts_pkg::PH_R_ADDR2: begin
          if (item.nacked) begin
            // abort on nack
            bundle.item[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_STOP, 8'h00, 1'b0, 1'b0);
            bundle.item[1] = i2crts_pkg::mk_res(i2crts_pkg::ACT_DONE, 8'h00, 1'b0, 1'b0);
            bundle.count   = 3'd2;
          end else if (phase_r == i2crts_pkg::PH_W_ADDR ||
                       phase_r == i2crts_pkg::PH_R_ADDR) begin
            bundle.item[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_SEND, reg_r, 1'b0, 1'b0);
            bundle.count   = 3'd1;
          end else if (phase_r == i2crts_pkg::PH_R_REG) begin
            // stop, then start again with read flag
            bundle.item[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_STOP, 8'h00, 1'b0, 1'b0);
            bundle.item[1] = i2crts_pkg::mk_res(i2crts_pkg::ACT_START, 8'h00, 1'b0, 1'b0);
            bundle.item[2] = i2crts_pkg::mk_res(i2crts_pkg::ACT_SEND,
                                                addr_r | i2crts_pkg::READ_FLAG, 1'b0, 1'b0);
            bundle.count   = 3'd3;
          end else if (phase_r == i2crts_pkg::PH_R_ADDR2) begin
            bundle.item[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_RECV, 8'h00, 1'b0, 1'b0);
            bundle.count   = 3'd1;
          end else if (left_wr == '0) begin
            bundle.item[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_STOP, 8'h00, 1'b0, 1'b0);
            bundle.item[1] = i2crts_pkg::mk_res(i2crts_pkg::ACT_DONE, 8'h00, 1'b0, 1'b1);
            bundle.count   = 3'd2;
          end else begin
            bundle.item[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_NEED, 8'h00, 1'b0, 1'b0);
            bundle.count   = 3'd1;
          end
        end
        default: begin
          bundle.count = 3'd0;
        end
      endcase
    end else if (cmd == i2crts_pkg::CMD_WRITE_BYTE) begin
      if (phase_r == i2crts_pkg::PH_W_WAIT) begin
        bundle.item[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_SEND, item.data_byte,
                                            1'b0, 1'b0);
        bundle.count   = 3'd1;
      end
    end else if (cmd == i2crts_pkg::CMD_RX_BYTE) begin
      if (phase_r == i2crts_pkg::PH_R_DATA) begin
        bundle.item[0] = i2crts_pkg::mk_res(i2crts_pkg::ACT_READ, item.data_byte,
                                            1'b0, 1'b0);
        if (left_r <= i2crts_pkg::COUNT_WIDTH'(1)) begin
          // final byte: nack, stop, done
          bundle.item[1] = i2crts_pkg::mk_res(i2crts_pkg::ACT_ACKBIT, 8'h00, 1'b1, 1'b0);
          bundle.item[2] = i2crts_pkg::mk_res(i2crts_pkg::ACT_STOP, 8'h00, 1'b0, 1'b0);
          bundle.item[3] = i2crts_pkg::mk_res(i2crts_pkg::ACT_DONE, 8'h00, 1'b0, 1'b1);
          bundle.count   = 3'd4;
        end else begin
          bundle.item[1] = i2crts_pkg::mk_res(i2crts_pkg::ACT_ACKBIT, 8'h00, 1'b0, 1'b0);
          bundle.item[2] = i2crts_pkg::mk_res(i2crts_pkg::ACT_RECV, 8'h00, 1'b0, 1'b0);
          bundle.count   = 3'd3;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2crts_pkg::PH_IDLE;
      addr_r  <= '0;
      reg_r   <= '0;
      left_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      reg_r   <= reg_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// File: hdl/i2crts_emit.sv
// result register that hands out one result per cycle while out_ready is high
module i2crts_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  i2crts_pkg::bundle_t   bundle,
  output logic                  load_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2crts_pkg::out_item_t out_data
);

  i2crts_pkg::out_item_t [i2crts_pkg::MAX_RESULTS-1:0] ent_r;
  logic [2:0] cnt_r;
  logic [1:0] idx_r;
  logic       busy;
  logic       is_last;
  logic       fin;

  assign busy    = (cnt_r != 3'd0);
  assign is_last = ({1'b0, idx_r} == (cnt_r - 3'd1));
  assign fin     = busy && out_ready && is_last;
  assign load_ok = !busy || fin;

  // current result, last flag from position
  always_comb begin
    out_valid     = busy;
    out_data      = ent_r[idx_r];
    out_data.last = is_last;
  end

  // payload holds its entries
  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= bundle.item;
    end
  end

  // count and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      cnt_r <= bundle.count;
      idx_r <= 2'd0;
    end else if (fin) begin
      cnt_r <= 3'd0;
      idx_r <= 2'd0;
    end else if (busy && out_ready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule
